### rtl/core/kalman_angle_filter_top_defines.svh
// Assertion macros for the Kalman angle filter.
`ifndef KALMAN_ANGLE_FILTER_TOP_DEFINES_SVH
`define KALMAN_ANGLE_FILTER_TOP_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define KAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
// Assert that an antecedent implies a consequent in the same cycle.
`define KAF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`endif

### rtl/core/kaf_pkg.sv
// Package for the Kalman angle filter: types, constants and register indexes.
package kaf_pkg;
   localparam int unsigned REG_WIDTH = 31;
   localparam int unsigned CSR_ADDR_WIDTH = 2;
   localparam logic [30:0] ANGLE_NOISE_RESET = 31'd10737418;
   localparam logic [30:0] BIAS_NOISE_RESET = 31'd1073742;
   localparam logic [30:0] MEASURE_NOISE_RESET = 31'd37580964;
   localparam logic [30:0] TIME_STEP_RESET = 31'd30064771;
   localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

   localparam logic [1:0] CSR_ANGLE_NOISE = 2'd0;
   localparam logic [1:0] CSR_BIAS_NOISE = 2'd1;
   localparam logic [1:0] CSR_MEASURE_NOISE = 2'd2;
   localparam logic [1:0] CSR_TIME_STEP = 2'd3;

   typedef struct packed {
      logic signed [24:0] accel_angle;
      logic signed [27:0] gyro_rate;
   } req_type;

   typedef struct packed {
      logic signed [31:0] angle_estimate;
      logic signed [31:0] corrected_rate;
   } rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) r = 32'sh7fffffff;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction
endpackage

### rtl/core/kaf_divider.sv
// Restoring divider giving (num << 30) / den truncated toward zero, saturated, one bit a cycle.
module kaf_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [31:0]  num,
   input  logic [32:0]         den,
   output logic                done,
   output logic signed [31:0]  quot
);
   localparam int unsigned NB = 62;
   logic [61:0] dvd_ff, dvd_in;
   logic [32:0] rem_ff, rem_in;
   logic [61:0] q_ff, q_in;
   logic [32:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] trial;
   logic [31:0] mag;
   logic [63:0] qs;

   always_comb begin
      dvd_in = dvd_ff; rem_in = rem_ff; q_in = q_ff; den_in = den_ff;
      neg_in = neg_ff; cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      mag = num[31] ? 32'(-num) : 32'(num);
      trial = {rem_ff, dvd_ff[61]} - {1'b0, den_ff};
      if (start) begin
         dvd_in = {mag, 30'd0};
         rem_in = '0; q_in = '0; den_in = den; neg_in = num[31];
         cnt_in = 6'(NB); busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[60:0], 1'b0};
         if (!trial[33]) begin
            rem_in = trial[32:0]; q_in = {q_ff[60:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], dvd_ff[61]}; q_in = {q_ff[60:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in; rem_ff <= rem_in; q_ff <= q_in;
      den_ff <= den_in; neg_ff <= neg_in;
   end

   // truncate toward zero: negate the magnitude quotient
   always_comb begin
      qs = neg_ff ? -{2'b00, q_ff} : {2'b00, q_ff};
      quot = kaf_pkg::sat32(66'(signed'(qs)));
   end
   assign done = done_ff;
endmodule

### rtl/core/kalman_angle_filter_top.sv
// Top level of the two-state Kalman angle filter with a shared multiplier.
//  channel | dir | handshake          | payload
//  req_    | in  | req_valid/req_stall| kaf_pkg::req_type
//  rsp_    | out | rsp_valid/rsp_stall| kaf_pkg::rsp_type
//  csr_    | in  | csr_valid/csr_ready| csr_index, csr_data
// Each item runs ten multiplies on the shared 32x32 multiplier and two 62-step
// divisions, through S_MUL, S_DIV0, S_DIV1, S_UPD and S_OUT; a new beat is accepted
// only after S_OUT has loaded the previous result into the output register.
// Reset is synchronous and restores the CSR registers, the filter state and the control state.
// Hold the result under rsp_stall; the next item may run meanwhile and waits at
// its end while the output register is still full.
module kalman_angle_filter_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  kaf_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output kaf_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [kaf_pkg::CSR_ADDR_WIDTH-1:0]   csr_index,
   input  logic [31:0]                          csr_data
);
   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_DIV0, S_DIV1, S_UPD, S_OUT
   } state_type;

   state_type state_ff;
   logic [3:0] step_ff;
   logic [30:0] an_ff, bn_ff, mn_ff, dt_ff;
   logic signed [31:0] ang_ff, bias_ff, aa_ff, ab_ff, ba_ff, bb_ff;
   logic signed [31:0] acc_ff, gyr_ff, err_ff, k0_ff, k1_ff, t0_ff, t1_ff;
   logic signed [31:0] pa_ff, pb_ff;
   logic signed [63:0] prod_ff;
   logic               rv_ff;
   kaf_pkg::rsp_type   rsp_ff;
   logic               dstart_ff;
   logic               ddone;
   logic signed [31:0] dq;
   logic signed [31:0] dnum;
   logic [32:0]        dden;
   logic signed [32:0] e_val;
   logic signed [33:0] pq;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;
   assign e_val = $signed({2'b00, mn_ff}) + 33'(aa_ff);
   // floor shift of last product
   assign pq = 34'(prod_ff >>> 30);

   kaf_divider u_div (
      .clock(clock), .reset(reset), .start(dstart_ff), .num(dnum), .den(dden),
      .done(ddone), .quot(dq)
   );
   assign dden = e_val[32:0];
   assign dnum = (state_ff == S_DIV0) ? aa_ff : ba_ff;

   always_ff @(posedge clock) begin
      prod_ff <= 64'(pa_ff) * 64'(pb_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; step_ff <= '0; rv_ff <= 1'b0;
         dstart_ff <= 1'b0;
         an_ff <= kaf_pkg::ANGLE_NOISE_RESET; bn_ff <= kaf_pkg::BIAS_NOISE_RESET;
         mn_ff <= kaf_pkg::MEASURE_NOISE_RESET; dt_ff <= kaf_pkg::TIME_STEP_RESET;
         ang_ff <= '0; bias_ff <= '0; aa_ff <= kaf_pkg::Q30_ONE; ab_ff <= '0;
         ba_ff <= '0; bb_ff <= kaf_pkg::Q30_ONE;
      end else begin
         dstart_ff <= ((state_ff == S_MUL) && (step_ff >= 4'd7)) ||
                      ((state_ff == S_DIV0) && ddone);
         rv_ff <= (state_ff == S_OUT) || (rv_ff && rsp_stall);
         if (csr_valid) begin
            unique case (csr_index)
               kaf_pkg::CSR_ANGLE_NOISE:   an_ff <= csr_data[30:0];
               kaf_pkg::CSR_BIAS_NOISE:    bn_ff <= csr_data[30:0];
               kaf_pkg::CSR_MEASURE_NOISE: mn_ff <= csr_data[30:0];
               kaf_pkg::CSR_TIME_STEP:     dt_ff <= csr_data[30:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  acc_ff <= 32'(req_data.accel_angle);
                  gyr_ff <= 32'(req_data.gyro_rate);
                  pa_ff <= kaf_pkg::sat32(66'(req_data.gyro_rate) - 66'(bias_ff));
                  pb_ff <= $signed({1'b0, dt_ff});
                  step_ff <= 4'd0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               // odd steps: consume product of previous operands, load next; even steps wait
               step_ff <= step_ff + 4'd1;
               unique case (step_ff)
                  4'd0: ; // wait for product
                  4'd1: begin
                     ang_ff <= kaf_pkg::sat32(66'(ang_ff) + 66'(pq));
                     pa_ff <= kaf_pkg::sat32(66'($signed({1'b0, an_ff})) - 66'(ab_ff)
                                             - 66'(ba_ff));
                  end
                  4'd2: ;
                  4'd3: begin
                     aa_ff <= kaf_pkg::sat32(66'(aa_ff) + 66'(pq));
                     pa_ff <= bb_ff;
                  end
                  4'd4: ;
                  4'd5: begin
                     ab_ff <= kaf_pkg::sat32(66'(ab_ff) - 66'(pq));
                     ba_ff <= kaf_pkg::sat32(66'(ba_ff) - 66'(pq));
                     pa_ff <= $signed({1'b0, bn_ff});
                  end
                  4'd6: ;
                  default: begin
                     bb_ff <= kaf_pkg::sat32(66'(bb_ff) + 66'(pq));
                     err_ff <= kaf_pkg::sat32(66'(acc_ff) - 66'(ang_ff));
                     state_ff <= S_DIV0;
                  end
               endcase
            end
            S_DIV0: begin
               if (ddone) begin
                  k0_ff <= (e_val > 0) ? dq : '0;
                  state_ff <= S_DIV1;
               end
            end
            S_DIV1: begin
               if (ddone) begin
                  k1_ff <= (e_val > 0) ? dq : '0;
                  t0_ff <= aa_ff; t1_ff <= ab_ff;
                  pa_ff <= k0_ff; pb_ff <= aa_ff;
                  state_ff <= S_UPD;
                  step_ff <= '0;
               end
            end
            S_UPD: begin
               step_ff <= step_ff + 4'd1;
               unique case (step_ff)
                  4'd0, 4'd2, 4'd4, 4'd6, 4'd8: ;
                  4'd1: begin
                     aa_ff <= kaf_pkg::sat32(66'(aa_ff) - 66'(pq));
                     pb_ff <= t1_ff;
                  end
                  4'd3: begin
                     ab_ff <= kaf_pkg::sat32(66'(ab_ff) - 66'(pq));
                     pa_ff <= k1_ff; pb_ff <= t0_ff;
                  end
                  4'd5: begin
                     ba_ff <= kaf_pkg::sat32(66'(ba_ff) - 66'(pq));
                     pb_ff <= t1_ff;
                  end
                  4'd7: begin
                     bb_ff <= kaf_pkg::sat32(66'(bb_ff) - 66'(pq));
                     pa_ff <= k0_ff; pb_ff <= err_ff;
                  end
                  4'd9: begin
                     ang_ff <= kaf_pkg::sat32(66'(ang_ff) + 66'(pq));
                     pa_ff <= k1_ff;
                  end
                  4'd10: ;
                  default: begin
                     bias_ff <= kaf_pkg::sat32(66'(bias_ff) + 66'(pq));
                     state_ff <= S_OUT;
                  end
               endcase
            end
            S_OUT: begin
               if (!rv_ff || !rsp_stall) begin
                  rsp_ff.angle_estimate <= ang_ff;
                  rsp_ff.corrected_rate <= kaf_pkg::sat32(66'(gyr_ff) - 66'(bias_ff));
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### rtl/core/kaf_checker.sv
// Port checker for the Kalman angle filter, bound to the top level.
`include "kalman_angle_filter_top_defines.svh"
module kaf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input kaf_pkg::rsp_type rsp_data
);
   `KAF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `KAF_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall)
   `KAF_ASSERT_NEXT(a_idle_quiet, clock, reset, !req_stall && !rsp_valid, !rsp_valid)
   `KAF_ASSERT_NOW(a_stall_known, clock, reset, 1'b1, !$isunknown(req_stall))
endmodule

bind kalman_angle_filter_top kaf_checker u_kaf_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
